### design/bsd_pkg.sv
// ----------------------------------------------------------------------------
// bsd_pkg
// shared types and constants of the bounded sorted deque
// ----------------------------------------------------------------------------
package bsd_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_W     = 32;
  localparam int AW         = $clog2(CAPACITY);
  localparam int DEPTH      = 1 << AW;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int OUT_USER_W = 2;
  localparam int OUT_DATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

  // bit positions inside the result tdata
  localparam int ELEM_LO  = 0;
  localparam int MATCH_LO = DATA_W;
  localparam int FILL_LO  = DATA_W + CNT_W;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [AW-1:0]     addr_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DELETE     = 3'd4,
    CMD_COUNT      = 3'd5,
    CMD_SORT       = 3'd6,
    CMD_SHOW       = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_LD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DEL_RD,
    S_DEL_WR,
    S_SORT_RD0,
    S_SORT_LD0,
    S_SORT_STEP,
    S_SORT_END,
    S_EMIT_RD,
    S_EMIT_LD,
    S_RESP
  } state_t;

endpackage

### design/bsd_ram.sv
// ----------------------------------------------------------------------------
// bsd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module bsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/bounded_sorted_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_sorted_deque_unit
// deque of up to CAPACITY signed words with delete, count and stable sort
// ----------------------------------------------------------------------------
// usage
//   input channel: in_tuser carries the command, in_tdata the value. one
//   command is taken at a time; in_tready is high only while the unit is idle
//   result channel: one transfer per result, out_tlast on the final result of
//   a command. show and sort give one transfer per element, front to back
//   count and delete scan the store front to back; delete then closes the
//   gap by shifting the later elements forward. sort runs bubble passes and
//   then gives the elements as show does. all storage work goes through one
//   ram port pair and one shared comparator
//   the cells live in a circular ram indexed from a head pointer, so pushes
//   and pops at either end need no shifting
//   reset: synchronous, active low; the store comes up empty, ram contents
//   are not cleared (never read before written)
//   stall: a result waits in the output register until out_tready; the
//   sequencer does not advance meanwhile
// ----------------------------------------------------------------------------
module bounded_sorted_deque_unit
  import bsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [IN_USER_W-1:0]  in_tuser,   // [2:0] command
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // element, match_count, fill, zero pad
  output logic [OUT_USER_W-1:0] out_tuser,  // [1:0] status
  output logic                  out_tlast
);

  // control state
  state_t state_r, state_nxt;
  addr_t  head_r, head_nxt;
  cnt_t   occ_r, occ_nxt;

  // sequencer payload
  cmd_t   cmd_r, cmd_nxt;
  data_t  value_r, value_nxt;
  cnt_t   idx_r, idx_nxt;      // logical index being walked
  cnt_t   end_r, end_nxt;      // last index of the current sort pass
  cnt_t   cnt_r, cnt_nxt;      // running match count
  data_t  carry_r, carry_nxt;  // element being bubbled up

  // output register
  status_t out_status_r, out_status_nxt;
  data_t   out_elem_r, out_elem_nxt;
  cnt_t    out_match_r, out_match_nxt;
  cnt_t    out_fill_r, out_fill_nxt;
  logic    out_last_r, out_last_nxt;

  // ram port
  logic  ram_we;
  addr_t ram_waddr, ram_raddr;
  data_t ram_wdata, ram_rdata;

  // shared comparator
  data_t cmp_b;
  logic  cmp_eq, cmp_lt;

  logic  in_xfer, out_xfer;
  logic  is_full, is_empty;
  cnt_t  last_idx;
  logic  at_last, at_end, del_done;

  // logical index to ram address around the head pointer
  function automatic addr_t phys(input addr_t head, input cnt_t idx);
    return addr_t'(head + idx[AW-1:0]);
  endfunction

  bsd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  assign is_full  = (occ_r == cnt_t'(CAPACITY));
  assign is_empty = (occ_r == '0);
  assign last_idx = cnt_t'(occ_r - 1'b1);
  assign at_last  = (idx_r == last_idx);
  assign at_end   = (idx_r == end_r);
  assign del_done = (cnt_t'(idx_r + 1'b1) == last_idx);

  // sort compares against the bubbled element, scans against the command value
  assign cmp_b  = (state_r == S_SORT_STEP) ? carry_r : value_r;
  assign cmp_eq = (ram_rdata == cmp_b);
  assign cmp_lt = ($signed(ram_rdata) < $signed(cmp_b));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (cmd_r inside {CMD_PUSH_FRONT, CMD_PUSH_BACK}) begin
          state_nxt = S_RESP;
        end else if (is_empty) begin
          state_nxt = S_RESP;
        end else begin
          case (cmd_r)
            CMD_POP_FRONT, CMD_POP_BACK: state_nxt = S_POP_LD;
            CMD_DELETE, CMD_COUNT:       state_nxt = S_SCAN_RD;
            CMD_SORT: begin
              state_nxt = (occ_r == cnt_t'(1)) ? S_EMIT_RD : S_SORT_RD0;
            end
            default:                     state_nxt = S_EMIT_RD;
          endcase
        end
      end
      S_POP_LD:   state_nxt = S_RESP;
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (cmd_r == CMD_DELETE && cmp_eq) begin
          state_nxt = at_last ? S_RESP : S_DEL_RD;
        end else if (at_last) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DEL_RD:   state_nxt = S_DEL_WR;
      S_DEL_WR: begin
        if (del_done) begin
          state_nxt = S_RESP;
        end
      end
      S_SORT_RD0: state_nxt = S_SORT_LD0;
      S_SORT_LD0: state_nxt = S_SORT_STEP;
      S_SORT_STEP: begin
        if (at_end) begin
          state_nxt = S_SORT_END;
        end
      end
      S_SORT_END: begin
        state_nxt = (end_r == cnt_t'(1)) ? S_EMIT_RD : S_SORT_RD0;
      end
      S_EMIT_RD:  state_nxt = S_EMIT_LD;
      S_EMIT_LD:  state_nxt = S_RESP;
      S_RESP: begin
        if (out_xfer) begin
          state_nxt = out_last_r ? S_IDLE : S_EMIT_RD;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_nxt       = head_r;
    occ_nxt        = occ_r;
    cmd_nxt        = cmd_r;
    value_nxt      = value_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    cnt_nxt        = cnt_r;
    carry_nxt      = carry_r;
    out_status_nxt = out_status_r;
    out_elem_nxt   = out_elem_r;
    out_match_nxt  = out_match_r;
    out_fill_nxt   = out_fill_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, idx_r);
    ram_wdata      = value_r;
    ram_raddr      = phys(head_r, idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt   = cmd_t'(in_tuser[2:0]);
          value_nxt = in_tdata[DATA_W-1:0];
          idx_nxt   = '0;
          cnt_nxt   = '0;
        end
      end
      S_DISPATCH: begin
        // default single-result response
        out_status_nxt = ST_OK;
        out_elem_nxt   = '0;
        out_match_nxt  = '0;
        out_fill_nxt   = occ_r;
        out_last_nxt   = 1'b1;
        if (cmd_r inside {CMD_PUSH_FRONT, CMD_PUSH_BACK}) begin
          if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ram_we       = 1'b1;
            occ_nxt      = cnt_t'(occ_r + 1'b1);
            out_fill_nxt = cnt_t'(occ_r + 1'b1);
            if (cmd_r == CMD_PUSH_FRONT) begin
              head_nxt  = addr_t'(head_r - 1'b1);
              ram_waddr = addr_t'(head_r - 1'b1);
            end else begin
              ram_waddr = phys(head_r, occ_r);
            end
          end
        end else if (is_empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          case (cmd_r)
            CMD_POP_FRONT: ram_raddr = head_r;
            CMD_POP_BACK:  ram_raddr = phys(head_r, last_idx);
            CMD_SORT:      end_nxt   = last_idx;
            default:       ram_raddr = phys(head_r, idx_r);
          endcase
        end
      end
      S_POP_LD: begin
        out_elem_nxt = ram_rdata;
        occ_nxt      = last_idx;
        out_fill_nxt = last_idx;
        if (cmd_r == CMD_POP_FRONT) begin
          head_nxt = addr_t'(head_r + 1'b1);
        end
      end
      S_SCAN_RD: begin
        ram_raddr = phys(head_r, idx_r);
      end
      S_SCAN_CMP: begin
        if (cmd_r == CMD_COUNT && cmp_eq) begin
          cnt_nxt = cnt_t'(cnt_r + 1'b1);
        end
        if (cmd_r == CMD_DELETE && cmp_eq) begin
          if (at_last) begin
            // match on the back element: nothing to close up
            occ_nxt      = last_idx;
            out_fill_nxt = last_idx;
          end
        end else if (at_last) begin
          if (cmd_r == CMD_COUNT) begin
            out_match_nxt = cnt_t'(cnt_r + cnt_t'(cmp_eq));
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end else begin
          idx_nxt = cnt_t'(idx_r + 1'b1);
        end
      end
      S_DEL_RD: begin
        ram_raddr = phys(head_r, cnt_t'(idx_r + 1'b1));
      end
      S_DEL_WR: begin
        // close the gap one cell per cycle
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, idx_r);
        ram_wdata = ram_rdata;
        if (del_done) begin
          occ_nxt      = last_idx;
          out_fill_nxt = last_idx;
        end else begin
          ram_raddr = phys(head_r, cnt_t'(idx_r + 2'd2));
          idx_nxt   = cnt_t'(idx_r + 1'b1);
        end
      end
      S_SORT_RD0: begin
        ram_raddr = head_r;
        idx_nxt   = cnt_t'(1);
      end
      S_SORT_LD0: begin
        carry_nxt = ram_rdata;
        ram_raddr = phys(head_r, idx_r);
      end
      S_SORT_STEP: begin
        // strict less-than keeps equal values in order
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, cnt_t'(idx_r - 1'b1));
        if (cmp_lt) begin
          ram_wdata = ram_rdata;
        end else begin
          ram_wdata = carry_r;
          carry_nxt = ram_rdata;
        end
        if (!at_end) begin
          ram_raddr = phys(head_r, cnt_t'(idx_r + 1'b1));
          idx_nxt   = cnt_t'(idx_r + 1'b1);
        end
      end
      S_SORT_END: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, end_r);
        ram_wdata = carry_r;
        end_nxt   = cnt_t'(end_r - 1'b1);
        idx_nxt   = '0;
      end
      S_EMIT_RD: begin
        ram_raddr = phys(head_r, idx_r);
      end
      S_EMIT_LD: begin
        out_status_nxt = ST_OK;
        out_elem_nxt   = ram_rdata;
        out_match_nxt  = '0;
        out_fill_nxt   = occ_r;
        out_last_nxt   = at_last;
      end
      S_RESP: begin
        if (out_xfer && !out_last_r) begin
          idx_nxt = cnt_t'(idx_r + 1'b1);
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    value_r      <= value_nxt;
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    cnt_r        <= cnt_nxt;
    carry_r      <= carry_nxt;
    out_status_r <= out_status_nxt;
    out_elem_r   <= out_elem_nxt;
    out_match_r  <= out_match_nxt;
    out_fill_r   <= out_fill_nxt;
    out_last_r   <= out_last_nxt;
  end

  // port side
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_RESP);
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    out_tdata                            = '0;
    out_tdata[ELEM_LO +: DATA_W]         = out_elem_r;
    out_tdata[MATCH_LO +: CNT_W]         = out_match_r;
    out_tdata[FILL_LO +: CNT_W]          = out_fill_r;
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cnt_t'(CAPACITY))
    else $error("occupancy above capacity");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("command taken while a result is pending");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("no return to idle after final result");

  a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_FULL) |-> (out_fill_r == cnt_t'(CAPACITY)))
    else $error("full status with store not full");

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for bounded_sorted_deque_unit: commands are streamed in
// with random gaps and result backpressure, a shadow deque works out the
// results of each accepted command, and every result transfer is compared
// field by field against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int HOLD_CYCLES    = 300;   // long result-side hold-off
  localparam int RANDOM_ITEMS   = 360;
  localparam int SETTLE_CYCLES  = 64;    // quiet time after the last result

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] value
  logic [IN_USER_W-1:0]  in_tuser;   // [2:0] command
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [31:0] element, [36:32] match_count, [41:37] fill
  logic [OUT_USER_W-1:0] out_tuser;  // [1:0] status
  logic                  out_tlast;

  // one predicted result transfer
  typedef struct {
    status_t status;
    data_t   element;
    cnt_t    match_num;
    cnt_t    fill;
    logic    last;
  } result_t;

  result_t pending_results[$];  // predictions not yet matched, oldest first
  data_t   shadow_cells[$];     // front of the deque at index 0
  int      errors;
  bit      quiet;               // no random idling on either side while set

  // result-side hold-off request: main process bumps hold_seq, receiver loads
  int      hold_len;
  int      hold_seq;
  int      hold_seen;
  int      hold_left;
  int      stuck_cycles;

  bounded_sorted_deque_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // shadow deque
  // --------------------------------------------------------------------------

  // fill is taken from the shadow store as it stands after the command
  function automatic void expect_result(status_t st, data_t elem, cnt_t hits, logic fin);
    result_t r;
    r.status    = st;
    r.element   = elem;
    r.match_num = hits;
    r.fill      = cnt_t'(shadow_cells.size());
    r.last      = fin;
    pending_results.push_back(r);
  endfunction

  // show and sort: one transfer per element, front to back
  function automatic void expect_run();
    foreach (shadow_cells[i])
      expect_result(ST_OK, shadow_cells[i], '0, i == shadow_cells.size() - 1);
  endfunction

  function automatic void deque_apply(cmd_t c, data_t v);
    data_t held;
    int    hits;
    int    where;
    int    j;
    if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK) begin
      // full store rejects the push and stays as it is
      if (shadow_cells.size() >= CAPACITY) begin
        expect_result(ST_FULL, '0, '0, 1'b1);
      end else begin
        if (c == CMD_PUSH_FRONT) shadow_cells.push_front(v);
        else shadow_cells.push_back(v);
        expect_result(ST_OK, '0, '0, 1'b1);
      end
    end else if (shadow_cells.size() == 0) begin
      // every other command on an empty store gives a single empty status
      expect_result(ST_EMPTY, '0, '0, 1'b1);
    end else begin
      case (c)
        CMD_POP_FRONT: begin
          held = shadow_cells.pop_front();
          expect_result(ST_OK, held, '0, 1'b1);
        end
        CMD_POP_BACK: begin
          held = shadow_cells.pop_back();
          expect_result(ST_OK, held, '0, 1'b1);
        end
        CMD_DELETE: begin
          // only the first match from the front goes
          where = -1;
          foreach (shadow_cells[i])
            if (where < 0 && shadow_cells[i] == v) where = i;
          if (where >= 0) begin
            shadow_cells.delete(where);
            expect_result(ST_OK, '0, '0, 1'b1);
          end else begin
            expect_result(ST_NOT_FOUND, '0, '0, 1'b1);
          end
        end
        CMD_COUNT: begin
          hits = 0;
          foreach (shadow_cells[i])
            if (shadow_cells[i] == v) hits++;
          expect_result(ST_OK, '0, cnt_t'(hits), 1'b1);
        end
        CMD_SORT: begin
          // stable ascending insertion sort on signed values
          for (int i = 1; i < shadow_cells.size(); i++) begin
            held = shadow_cells[i];
            j = i;
            while (j > 0 && $signed(shadow_cells[j-1]) > $signed(held)) begin
              shadow_cells[j] = shadow_cells[j-1];
              j--;
            end
            shadow_cells[j] = held;
          end
          expect_run();
        end
        default: expect_run();
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h element %0h",
                 $time, out_tuser, out_tdata[ELEM_LO +: DATA_W]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("element", want.element, out_tdata[ELEM_LO +: DATA_W]);
        check_field("match_count", want.match_num, out_tdata[MATCH_LO +: CNT_W]);
        check_field("fill", want.fill, out_tdata[FILL_LO +: CNT_W]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // result side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 15);
    end
  end

  // hang detection: counts cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // called and returning at a falling edge; the command is predicted at the
  // rising edge where its transfer happens
  task automatic send_cmd(cmd_t c, data_t v);
    while (!quiet && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= v;
    do @(posedge clk); while (in_tready !== 1'b1);
    deque_apply(c, v);
    @(negedge clk);
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly small values so delete and count hit, plus full-range, extremes and held values
  function automatic data_t random_value();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) return data_t'(int'($urandom_range(0, 6)) - 3);
    if (pick <= 7) return data_t'($urandom());
    if (pick == 8) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return '0;
        default: return '1;
      endcase
    end
    if (shadow_cells.size() > 0)
      return shadow_cells[$urandom_range(0, shadow_cells.size() - 1)];
    return data_t'($urandom());
  endfunction

  // push weight follows the fill level so the store wanders between empty and full
  task automatic send_random();
    int   roll;
    int   push_weight;
    cmd_t c;
    roll = $urandom_range(0, 99);
    if (shadow_cells.size() < 4) push_weight = 60;
    else if (shadow_cells.size() > 12) push_weight = 25;
    else push_weight = 45;
    if (roll < push_weight) begin
      c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 20) c = CMD_POP_FRONT;
      else if (roll < 40) c = CMD_POP_BACK;
      else if (roll < 62) c = CMD_DELETE;
      else if (roll < 84) c = CMD_COUNT;
      else if (roll < 92) c = CMD_SORT;
      else c = CMD_SHOW;
    end
    send_cmd(c, random_value());
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // every command that needs an element, on an empty store
  task automatic test_empty_store();
    send_cmd(CMD_POP_FRONT, 32'd1);
    send_cmd(CMD_POP_BACK, 32'd2);
    send_cmd(CMD_DELETE, 32'd5);
    send_cmd(CMD_COUNT, 32'd5);
    send_cmd(CMD_SORT, '0);
    send_cmd(CMD_SHOW, '1);
  endtask

  // both ends, value extremes, duplicate handling, misses and signed sort order
  task automatic test_ends_and_extremes();
    send_cmd(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'h8000_0000);
    send_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_cmd(CMD_PUSH_FRONT, 32'd0);
    send_cmd(CMD_PUSH_BACK, 32'd5);
    send_cmd(CMD_PUSH_FRONT, 32'd5);
    send_cmd(CMD_COUNT, 32'd5);      // two matches
    send_cmd(CMD_COUNT, 32'd99);     // no match, still ok
    send_cmd(CMD_DELETE, 32'd5);     // front copy only
    send_cmd(CMD_DELETE, 32'd99);    // not found
    send_cmd(CMD_SHOW, '0);
    send_cmd(CMD_SORT, '0);
    send_cmd(CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_BACK, '0);
  endtask

  // fill to capacity without idling, reject pushes, then drain past empty
  task automatic test_full_store();
    quiet = 1'b1;
    while (shadow_cells.size() < CAPACITY)
      send_cmd($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_value());
    send_cmd(CMD_PUSH_FRONT, random_value());
    send_cmd(CMD_PUSH_BACK, random_value());
    send_cmd(CMD_COUNT, shadow_cells[$urandom_range(0, CAPACITY - 1)]);
    send_cmd(CMD_SHOW, '0);
    send_cmd(CMD_DELETE, shadow_cells[CAPACITY - 1]);
    send_cmd(CMD_PUSH_BACK, 32'h8000_0000);
    send_cmd(CMD_SORT, '0);
    send_cmd(CMD_SHOW, '0);
    while (shadow_cells.size() > 0)
      send_cmd($urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT, '0);
    send_cmd(CMD_POP_FRONT, '0);
    quiet = 1'b0;
  endtask

  // result side held off for a long stretch while commands keep coming
  task automatic test_output_stall();
    hold_len = HOLD_CYCLES;
    hold_seq++;
    repeat (24) send_random();
    wait_drain();
  endtask

  // random mix with an idle-free stretch and occasional full drains
  task automatic test_random_mix();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 120 && n < 180);
      send_random();
      if ($urandom_range(0, 39) == 0) wait_drain();
    end
    quiet = 1'b0;
  endtask

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_PUSH_FRONT;
    out_tready = 1'b0;
    quiet     = 1'b0;
    errors    = 0;
    hold_len  = 0;
    hold_seq  = 0;
    hold_seen = 0;
    hold_left = 0;
    stuck_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_store();
    test_ends_and_extremes();
    test_full_store();
    test_output_stall();
    test_random_mix();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
